>>> sv/orbit_step_rotation_top_assert.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ORBIT_STEP_ROTATION_TOP_ASSERT_SVH
`define ORBIT_STEP_ROTATION_TOP_ASSERT_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define OSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a condition that must hold in the cycle after its trigger.
`define OSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/osr_pkg.sv
package osr_pkg;

    // CORDIC arctangent table length and index width
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IW  = 5;

    // Default iteration count per CORDIC pass
    localparam int CORDIC_STEPS_DEF = 16;

    // Working width of the x/y CORDIC registers (Q8.22 plus growth)
    localparam int DW = 36;

    // Gain correction constant, 1/K in Q30
    localparam int KW = 30;
    localparam logic [KW-1:0] KINV_Q30 = 30'd652032874;

    // Gain multiply split: low part, high part, product and sum widths
    localparam int LO_W = 17;
    localparam int HI_W = DW - LO_W;
    localparam int MW   = HI_W + KW;
    localparam int AW   = DW + KW;

    typedef struct packed {
        logic                 capture;
        logic                 vec_init;
        logic                 vec_step;
        logic                 mul_lo;
        logic                 mul_hi;
        logic                 mul_acc;
        logic                 rot_init;
        logic                 rot_step;
        logic                 commit;
        logic [ATAN_IW-1:0]   idx;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEC_INIT,
        ST_VEC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_ROT_INIT,
        ST_ROT,
        ST_COMMIT
    } t_osr_state;

    // atan(2^-i), 2^31 = pi
    function automatic logic [31:0] osr_atan(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517C;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A2F;
            5'd19:   v = 32'h0000_0517;
            5'd20:   v = 32'h0000_028B;
            5'd21:   v = 32'h0000_0145;
            5'd22:   v = 32'h0000_00A2;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // Clamp a 20-bit signed sum to the 16-bit coordinate range
    function automatic logic signed [15:0] osr_sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> sv/osr_datapath.sv
module osr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  osr_pkg::t_dp_cmd     i_cmd,
    output osr_pkg::t_dp_stat    o_stat,
    input  logic                 i_action,
    input  logic signed [15:0]   i_center_x,
    input  logic signed [15:0]   i_center_y,
    input  logic signed [15:0]   i_depth_z,
    input  logic signed [15:0]   i_load_x,
    input  logic signed [15:0]   i_load_y,
    input  logic signed [15:0]   i_angle_step,
    output logic signed [15:0]   o_pos_x,
    output logic signed [15:0]   o_pos_y,
    output logic signed [15:0]   o_pos_z
);
    import osr_pkg::*;

    // Captured item
    logic                 r_action;
    logic signed [15:0]   r_cx;
    logic signed [15:0]   r_cy;
    logic signed [15:0]   r_dz;
    logic signed [15:0]   r_lx;
    logic signed [15:0]   r_ly;

    // Kept position and delivered depth
    logic signed [15:0]   r_px;
    logic signed [15:0]   r_py;
    logic signed [15:0]   r_oz;

    // CORDIC working registers
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
    logic [31:0]          r_ang;
    logic [MW-1:0]        r_prod;
    logic [AW-1:0]        r_acc;

    logic signed [16:0]   w_offx;
    logic signed [16:0]   w_offy;
    logic signed [DW-1:0] w_x0;
    logic signed [DW-1:0] w_y0;
    logic signed [DW-1:0] w_xs;
    logic signed [DW-1:0] w_ys;
    logic [31:0]          w_atan;
    logic [AW-1:0]        w_sum;
    logic [31:0]          w_zs;
    logic signed [DW-1:0] w_rx;
    logic signed [DW-1:0] w_ry;
    logic signed [19:0]   w_nx;
    logic signed [19:0]   w_ny;

    // Local offset widened to Q8.22
    always_comb begin
        w_offx = {r_px[15], r_px} - {r_cx[15], r_cx};
        w_offy = {r_py[15], r_py} - {r_cy[15], r_cy};
        w_x0   = DW'(w_offx) <<< 14;
        w_y0   = DW'(w_offy) <<< 14;
        w_xs   = r_x >>> i_cmd.idx;
        w_ys   = r_y >>> i_cmd.idx;
        w_atan = osr_atan(i_cmd.idx);
        w_sum  = r_acc + (AW'(r_prod) << LO_W);
        w_zs   = r_ang + {i_angle_step, 16'h0000};
        w_rx   = (r_x + DW'(8192)) >>> 14;
        w_ry   = (r_y + DW'(8192)) >>> 14;
        w_nx   = {{4{r_cx[15]}}, r_cx} + w_rx[19:0];
        w_ny   = {{4{r_cy[15]}}, r_cy} + w_ry[19:0];
    end

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_dz     <= i_depth_z;
            r_lx     <= i_load_x;
            r_ly     <= i_load_y;
        end
    end

    // CORDIC vectoring, gain correction and rotation
    always_ff @(posedge i_clk) begin
        if (i_cmd.vec_init) begin
            if (w_x0 < 0) begin
                r_x   <= -w_x0;
                r_y   <= -w_y0;
                r_ang <= 32'h8000_0000;
            end else begin
                r_x   <= w_x0;
                r_y   <= w_y0;
                r_ang <= 32'h0000_0000;
            end
        end else if (i_cmd.vec_step) begin
            if (!r_y[DW-1]) begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_ang <= r_ang + w_atan;
            end else begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_ang <= r_ang - w_atan;
            end
        end else if (i_cmd.mul_lo) begin
            r_prod <= MW'(r_x[LO_W-1:0]) * MW'(KINV_Q30);
        end else if (i_cmd.mul_hi) begin
            r_acc  <= AW'(r_prod);
            r_prod <= MW'(r_x[DW-1:LO_W]) * MW'(KINV_Q30);
        end else if (i_cmd.mul_acc) begin
            r_x <= w_sum[AW-1:KW];
        end else if (i_cmd.rot_init) begin
            r_y <= '0;
            if (w_zs[31:30] inside {2'b01, 2'b10}) begin
                r_x   <= -r_x;
                r_ang <= w_zs + 32'h8000_0000;
            end else begin
                r_ang <= w_zs;
            end
        end else if (i_cmd.rot_step) begin
            if (!r_ang[31]) begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_ang <= r_ang - w_atan;
            end else begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_ang <= r_ang + w_atan;
            end
        end
    end

    // Update the kept position on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
        end else if (i_cmd.commit) begin
            if (r_action) begin
                r_px <= r_lx;
                r_py <= r_ly;
            end else begin
                r_px <= osr_sat16(w_nx);
                r_py <= osr_sat16(w_ny);
            end
        end
    end

    // Hold the depth of the delivered beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_oz <= r_dz;
        end
    end

    assign o_stat.is_load = r_action;
    assign o_pos_x        = r_px;
    assign o_pos_y        = r_py;
    assign o_pos_z        = r_oz;

endmodule

>>> sv/osr_controller.sv
module osr_controller #(
    parameter int CORDIC_STEPS = osr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  osr_pkg::t_dp_stat    i_stat,
    output osr_pkg::t_dp_cmd     o_cmd
);
    import osr_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [ATAN_IW-1:0] LAST_IDX = ATAN_IW'(NSTEPS - 1);

    t_osr_state          r_state;
    t_osr_state          n_state;
    logic [ATAN_IW-1:0]  r_idx;
    logic [ATAN_IW-1:0]  n_idx;
    logic                r_pass;
    logic                n_pass;
    logic                r_out_valid;
    logic                n_out_valid;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_VEC_INIT;
                end
            end
            ST_VEC_INIT: begin
                n_idx = '0;
                if (i_stat.is_load) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.vec_init = 1'b1;
                    n_state        = ST_VEC;
                end
            end
            ST_VEC: begin
                o_cmd.vec_step = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_pass  = 1'b0;
                    n_state = ST_MUL_LO;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_MUL_ACC;
            end
            ST_MUL_ACC: begin
                o_cmd.mul_acc = 1'b1;
                if (r_pass) begin
                    n_state = ST_ROT_INIT;
                end else begin
                    n_pass  = 1'b1;
                    n_state = ST_MUL_LO;
                end
            end
            ST_ROT_INIT: begin
                o_cmd.rot_init = 1'b1;
                n_idx          = '0;
                n_state        = ST_ROT;
            end
            ST_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_COMMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_COMMIT: begin
                // wait until the output slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output beat valid: set on commit, drop when taken
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/orbit_step_rotation_top.sv
// Turns a kept point about a centre by a programmable angle step using two
// CORDIC passes in Q8.8 fixed point. For an advance beat (tuser = 0), one
// shared add/shift unit runs the vectoring and rotation iterations one per
// cycle, and the gain correction uses one 19x30 multiplier in low, high and
// accumulate steps for each of its two passes. A load beat (tuser = 1)
// skips the CORDIC passes and goes straight to commit. The result is held
// in an output register and the block waits to commit a new result while
// the previous one is still untaken. The angle step register is written
// through the cfg channel, which is always ready; write it only while the
// block is idle.
`include "orbit_step_rotation_top_assert.svh"

module orbit_step_rotation_top #(
    parameter int CORDIC_STEPS = osr_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // center_x [15:0], center_y [31:16], depth_z [47:32], load_x [63:48], load_y [79:64]
    input  logic [79:0]   s_axis_tdata,
    // action [0]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    output logic [47:0]   m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);
    import osr_pkg::*;

    logic signed [15:0]  r_angle_step;
    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic signed [15:0]  w_pos_x;
    logic signed [15:0]  w_pos_y;
    logic signed [15:0]  w_pos_z;

    // Angle step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_step <= '0;
        end else if (i_cfg_valid) begin
            r_angle_step <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    osr_controller #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    osr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_action     (s_axis_tuser),
        .i_center_x   (s_axis_tdata[15:0]),
        .i_center_y   (s_axis_tdata[31:16]),
        .i_depth_z    (s_axis_tdata[47:32]),
        .i_load_x     (s_axis_tdata[63:48]),
        .i_load_y     (s_axis_tdata[79:64]),
        .i_angle_step (r_angle_step),
        .o_pos_x      (w_pos_x),
        .o_pos_y      (w_pos_y),
        .o_pos_z      (w_pos_z)
    );

    assign m_axis_tdata = {w_pos_z, w_pos_y, w_pos_x};

    // The block is busy in the cycle after a beat is taken
    `OSR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    // A commit never overwrites an untaken result
    `OSR_ASSERT_NOW(a_commit_slot_free, w_cmd.commit, !m_axis_tvalid || m_axis_tready, "result overwritten")
    // A commit always presents a result
    `OSR_ASSERT_NEXT(a_commit_shows, w_cmd.commit, m_axis_tvalid, "commit without valid")

endmodule
